@@ sv/klfs_pkg.sv @@
// Package for the keypress LED fade slot block.
// Holds shared widths, register codes, payload structs and the sequencer state type.
// Has no dependencies.
package klfs_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int LED_COUNT_DEF  = 68;
    localparam int STEP_COUNT_DEF = 10;

    localparam int LED_W    = 7;
    localparam int STEP_W   = 4;
    localparam int POS_W    = 8;
    localparam int BRIGHT_W = 7;
    localparam int HUE_W    = 9;
    localparam int SAT_W    = 7;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [BRIGHT_W-1:0] MAX_BRIGHTNESS_RST   = 7'd100;
    localparam logic [HUE_W-1:0]    PRESS_HUE_RST        = 9'd0;
    localparam logic [SAT_W-1:0]    PRESS_SATURATION_RST = 7'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_BRIGHTNESS   = 2'd0,
        CFG_PRESS_HUE        = 2'd1,
        CFG_PRESS_SATURATION = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] max_brightness;
        logic [HUE_W-1:0]    press_hue;
        logic [SAT_W-1:0]    press_saturation;
    } cfg_t;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] key_position;
        logic             key_pressed;
    } cmd_t;

    typedef struct packed {
        logic [LED_W-1:0]    led_num;
        logic [HUE_W-1:0]    hue;
        logic [SAT_W-1:0]    saturation;
        logic [BRIGHT_W-1:0] brightness;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [LED_W-1:0]  led;
        logic [STEP_W-1:0] step;
    } slot_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_DIV,
        ST_KEY_MOD,
        ST_KEY_WR,
        ST_TICK_RD,
        ST_TICK_MUL,
        ST_TICK_DIV,
        ST_TICK_OFF,
        ST_TICK_END
    } state_t;

endpackage

@@ sv/klfs_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot store; depends on nothing.
module klfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/klfs_cfg.sv @@
// Configuration registers of the keypress LED fade slot block.
// Depends on klfs_pkg for the register codes and the cfg_t struct.
module klfs_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [klfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [klfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output klfs_pkg::cfg_t                      cfg
);

    logic [klfs_pkg::BRIGHT_W-1:0] max_brightness_reg;
    logic [klfs_pkg::HUE_W-1:0]    press_hue_reg;
    logic [klfs_pkg::SAT_W-1:0]    press_saturation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_brightness_reg   <= klfs_pkg::MAX_BRIGHTNESS_RST;
            press_hue_reg        <= klfs_pkg::PRESS_HUE_RST;
            press_saturation_reg <= klfs_pkg::PRESS_SATURATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                klfs_pkg::CFG_MAX_BRIGHTNESS:
                begin
                    max_brightness_reg <= cfg_data[klfs_pkg::BRIGHT_W-1:0];
                end
                klfs_pkg::CFG_PRESS_HUE:
                begin
                    press_hue_reg <= cfg_data[klfs_pkg::HUE_W-1:0];
                end
                klfs_pkg::CFG_PRESS_SATURATION:
                begin
                    press_saturation_reg <= cfg_data[klfs_pkg::SAT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.max_brightness   = max_brightness_reg;
    assign cfg.press_hue        = press_hue_reg;
    assign cfg.press_saturation = press_saturation_reg;

endmodule

@@ sv/klfs_seq.sv @@
// Sequencer of the keypress LED fade slot block: slot allocation, tick walk,
// read-modify-write of the slot RAM and result ordering. Depends on klfs_pkg.
module klfs_seq #(
    parameter int SLOT_COUNT = klfs_pkg::SLOT_COUNT_DEF,
    parameter int LED_COUNT  = klfs_pkg::LED_COUNT_DEF,
    parameter int STEP_COUNT = klfs_pkg::STEP_COUNT_DEF,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  klfs_pkg::cmd_t        cmd,
    input  klfs_pkg::cfg_t        cfg,
    output logic                  busy,
    output logic                  ram_re,
    output logic [SLOT_W-1:0]     ram_raddr,
    output logic                  ram_we,
    output logic [SLOT_W-1:0]     ram_waddr,
    output klfs_pkg::slot_entry_t ram_wdata,
    input  klfs_pkg::slot_entry_t ram_rdata,
    output logic                  result_valid,
    output klfs_pkg::result_t     result
);

    localparam int LED_CNT_W = $clog2(LED_COUNT + 1);
    localparam int POS_PROD_W = klfs_pkg::POS_W + klfs_pkg::RECIP_W;
    localparam int MOD_W = klfs_pkg::POS_W + LED_CNT_W;
    localparam int FADE_W = klfs_pkg::BRIGHT_W + klfs_pkg::STEP_W;
    localparam int FADE_PROD_W = FADE_W + klfs_pkg::RECIP_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [LED_CNT_W-1:0] LED_CONST = LED_CNT_W'(LED_COUNT);
    localparam logic [klfs_pkg::STEP_W-1:0] STEP_CONST = klfs_pkg::STEP_W'(STEP_COUNT);
    localparam logic [klfs_pkg::RECIP_W-1:0] LED_RECIP =
        klfs_pkg::RECIP_W'(((1 << klfs_pkg::RECIP_SHIFT) + LED_COUNT - 1) / LED_COUNT);
    localparam logic [klfs_pkg::RECIP_W-1:0] STEP_RECIP =
        klfs_pkg::RECIP_W'(((1 << klfs_pkg::RECIP_SHIFT) + STEP_COUNT - 1) / STEP_COUNT);

    klfs_pkg::state_t state_reg;
    klfs_pkg::state_t state_next;

    logic [SLOT_COUNT-1:0]         slot_busy_reg;
    logic [SLOT_W-1:0]             idx_reg;
    logic [klfs_pkg::POS_W-1:0]    pos_reg;
    logic [klfs_pkg::POS_W-1:0]    quot_reg;
    logic [klfs_pkg::LED_W-1:0]    led_reg;
    logic [klfs_pkg::STEP_W-1:0]   step_reg;
    logic [FADE_W-1:0]             prod_reg;
    logic                          pend_valid_reg;
    klfs_pkg::result_t             pend_reg;
    logic                          out_valid_reg;
    klfs_pkg::result_t             out_reg;

    logic                          free_found;
    logic [SLOT_W-1:0]             free_idx;
    logic [POS_PROD_W-1:0]         pos_prod;
    logic [MOD_W-1:0]              mod_full;
    logic [FADE_PROD_W-1:0]        fade_prod;
    logic [klfs_pkg::BRIGHT_W-1:0] fade_bright;
    logic                          last_slot;
    logic                          expire;

    logic                          push;
    klfs_pkg::result_t             push_data;
    logic                          flush;
    logic                          key_emit;
    logic                          set_busy;
    logic                          clr_busy;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!slot_busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign pos_prod    = POS_PROD_W'(pos_reg) * POS_PROD_W'(LED_RECIP);
    assign mod_full    = MOD_W'(pos_reg) - MOD_W'(quot_reg) * MOD_W'(LED_CONST);
    assign fade_prod   = FADE_PROD_W'(prod_reg) * FADE_PROD_W'(STEP_RECIP);
    assign fade_bright = fade_prod[klfs_pkg::RECIP_SHIFT +: klfs_pkg::BRIGHT_W];
    assign last_slot   = (idx_reg == LAST_SLOT);
    assign expire      = (step_reg == STEP_CONST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            klfs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.func == klfs_pkg::FUNC_TICK)
                    begin
                        state_next = klfs_pkg::ST_TICK_RD;
                    end
                    else if (cmd.key_pressed && free_found)
                    begin
                        state_next = klfs_pkg::ST_KEY_DIV;
                    end
                end
            end
            klfs_pkg::ST_KEY_DIV:
            begin
                state_next = klfs_pkg::ST_KEY_MOD;
            end
            klfs_pkg::ST_KEY_MOD:
            begin
                state_next = klfs_pkg::ST_KEY_WR;
            end
            klfs_pkg::ST_KEY_WR:
            begin
                state_next = klfs_pkg::ST_IDLE;
            end
            klfs_pkg::ST_TICK_RD:
            begin
                if (slot_busy_reg[idx_reg])
                begin
                    state_next = klfs_pkg::ST_TICK_MUL;
                end
                else if (last_slot)
                begin
                    state_next = klfs_pkg::ST_TICK_END;
                end
            end
            klfs_pkg::ST_TICK_MUL:
            begin
                state_next = klfs_pkg::ST_TICK_DIV;
            end
            klfs_pkg::ST_TICK_DIV:
            begin
                if (expire)
                begin
                    state_next = klfs_pkg::ST_TICK_OFF;
                end
                else if (last_slot)
                begin
                    state_next = klfs_pkg::ST_TICK_END;
                end
                else
                begin
                    state_next = klfs_pkg::ST_TICK_RD;
                end
            end
            klfs_pkg::ST_TICK_OFF:
            begin
                state_next = last_slot ? klfs_pkg::ST_TICK_END : klfs_pkg::ST_TICK_RD;
            end
            klfs_pkg::ST_TICK_END:
            begin
                state_next = klfs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = klfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = '{led: led_reg, step: step_reg};
        push      = 1'b0;
        push_data = '{led_num: led_reg, hue: cfg.press_hue,
                      saturation: cfg.press_saturation, brightness: fade_bright,
                      last: 1'b0};
        flush     = 1'b0;
        key_emit  = 1'b0;
        set_busy  = 1'b0;
        clr_busy  = 1'b0;
        unique case (state_reg)
            klfs_pkg::ST_KEY_WR:
            begin
                ram_we         = 1'b1;
                ram_wdata.step = '0;
                set_busy       = 1'b1;
                key_emit       = 1'b1;
            end
            klfs_pkg::ST_TICK_RD:
            begin
                ram_re = slot_busy_reg[idx_reg];
            end
            klfs_pkg::ST_TICK_DIV:
            begin
                push     = 1'b1;
                ram_we   = !expire;
                clr_busy = expire;
            end
            klfs_pkg::ST_TICK_OFF:
            begin
                push                 = 1'b1;
                push_data.hue        = '0;
                push_data.saturation = '0;
                push_data.brightness = '0;
            end
            klfs_pkg::ST_TICK_END:
            begin
                flush = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign ram_raddr = idx_reg;
    assign ram_waddr = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= klfs_pkg::ST_IDLE;
            slot_busy_reg  <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (set_busy)
            begin
                slot_busy_reg[idx_reg] <= 1'b1;
            end
            if (clr_busy)
            begin
                slot_busy_reg[idx_reg] <= 1'b0;
            end
            if (state_reg == klfs_pkg::ST_IDLE)
            begin
                idx_reg <= (cmd.func == klfs_pkg::FUNC_TICK) ? '0 : free_idx;
            end
            else if (state_next == klfs_pkg::ST_TICK_RD)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (key_emit || (push && pend_valid_reg) || (flush && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == klfs_pkg::ST_IDLE)
        begin
            pos_reg <= cmd.key_position;
        end
        if (state_reg == klfs_pkg::ST_KEY_DIV)
        begin
            quot_reg <= pos_prod[klfs_pkg::RECIP_SHIFT +: klfs_pkg::POS_W];
        end
        if (state_reg == klfs_pkg::ST_KEY_MOD)
        begin
            led_reg  <= mod_full[klfs_pkg::LED_W-1:0];
            step_reg <= '0;
        end
        if (state_reg == klfs_pkg::ST_TICK_MUL)
        begin
            led_reg  <= ram_rdata.led;
            step_reg <= ram_rdata.step + 1'b1;
            prod_reg <= FADE_W'(cfg.max_brightness) * FADE_W'(STEP_CONST - ram_rdata.step);
        end
        if (push)
        begin
            pend_reg <= push_data;
        end
        if (key_emit)
        begin
            out_reg <= '{led_num: led_reg, hue: cfg.press_hue,
                         saturation: cfg.press_saturation,
                         brightness: cfg.max_brightness, last: 1'b1};
        end
        else if (push)
        begin
            out_reg <= pend_reg;
        end
        else if (flush)
        begin
            out_reg <= '{led_num: pend_reg.led_num, hue: pend_reg.hue,
                         saturation: pend_reg.saturation,
                         brightness: pend_reg.brightness, last: 1'b1};
        end
    end

    assign busy         = (state_reg != klfs_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ sv/keypress_led_fade_slots.sv @@
// Top level of the keypress LED fade slot block.
// Depends on klfs_pkg, klfs_cfg, klfs_ram and klfs_seq.
//
// A command is taken when start is high and busy is low. A key press takes the lowest
// free fade slot and gives one full-brightness result after the divide, modulo and
// write states; a key release, or a press with every slot taken, gives nothing and
// leaves the block idle at once. A tick walks the slots in order: a free slot passes
// the read state only, a fading slot read, multiply and divide, and a slot that expires
// also an off state that turns it off; an end state finishes. The walk is paced by the
// read-modify-write of each slot through the single slot RAM. Results leave on
// result_valid for exactly one cycle each and cannot be held off, so the receiver must
// take every strobe; the final result of a command carries last. The slot busy flags
// are cleared by reset, so no clearing pass is needed after reset.
module keypress_led_fade_slots #(
    parameter int SLOT_COUNT = klfs_pkg::SLOT_COUNT_DEF,
    parameter int LED_COUNT  = klfs_pkg::LED_COUNT_DEF,
    parameter int STEP_COUNT = klfs_pkg::STEP_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  klfs_pkg::cmd_t                   cmd,
    output logic                             busy,
    output logic                             result_valid,
    output klfs_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [klfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [klfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    klfs_pkg::cfg_t        cfg;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_raddr;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    klfs_pkg::slot_entry_t ram_wdata;
    klfs_pkg::slot_entry_t ram_rdata;

    klfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    klfs_ram #(
        .WIDTH  ($bits(klfs_pkg::slot_entry_t)),
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    klfs_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .LED_COUNT  (LED_COUNT),
        .STEP_COUNT (STEP_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .cfg          (cfg),
        .busy         (busy),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTH
    // Every result comes from work started while the block was busy.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // A key release leaves the block idle.
    a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == klfs_pkg::FUNC_KEY && !cmd.key_pressed) |=> !busy)
        else $error("key release started work");

    // A tick always starts a walk over the slots.
    a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == klfs_pkg::FUNC_TICK) |=> busy)
        else $error("tick did not start a slot walk");

    // Every LED index leaving the block lies within the LED count.
    a_led_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.led_num < LED_COUNT))
        else $error("LED index out of range");
`endif

endmodule
